// ----- src/tlprf_pkg.sv -----
// ----------------------------------------------------------------------------
// tlprf_pkg
// Shared types and codes for the two-level priority record FIFO.
// ----------------------------------------------------------------------------
package tlprf_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_POPPED     = 3'd0,
        STAT_ACCEPTED   = 3'd1,
        STAT_DROPPED    = 3'd2,
        STAT_EMPTY      = 3'd3,
        STAT_MISALIGNED = 3'd4
    } status_e_t;

    // Command kinds decided by the front end
    typedef enum logic [1:0] {
        CMD_PUSH_START = 2'd0,
        CMD_PUSH_CONT  = 2'd1,
        CMD_POP        = 2'd2
    } cmd_kind_t;

    // Queue identifiers
    localparam logic QUEUE_HIGH = 1'b0;
    localparam logic QUEUE_LOW  = 1'b1;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        queue;
        logic [7:0]  data;
    } cmd_t;

endpackage

// ----- src/tlprf_front.sv -----
// ----------------------------------------------------------------------------
// tlprf_front
// Accepts input beats, classifies them into commands and buffers them in a
// two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module tlprf_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic               s_queue_select,
    input  logic [7:0]         s_data_byte,
    input  logic               s_first_of_record,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output tlprf_pkg::cmd_t    cmd
);
    import tlprf_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_idx_reg;
    logic       rd_idx_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    cmd_t       in_cmd;
    logic       push_en;
    logic       pop_en;

    always_comb begin
        in_cmd.queue = s_queue_select;
        in_cmd.data  = s_data_byte;
        if (s_operation) begin
            in_cmd.kind = CMD_POP;
        end else if (s_first_of_record) begin
            in_cmd.kind = CMD_PUSH_START;
        end else begin
            in_cmd.kind = CMD_PUSH_CONT;
        end
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_idx_reg];
    assign push_en   = s_valid && s_ready;
    assign pop_en    = cmd_valid && cmd_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push_en && !pop_en) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop_en && !push_en) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push_en) begin
                wr_idx_reg <= ~wr_idx_reg;
            end
            if (pop_en) begin
                rd_idx_reg <= ~rd_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            slot_reg[wr_idx_reg] <= in_cmd;
        end
    end

endmodule

// ----- src/tlprf_back.sv -----
// ----------------------------------------------------------------------------
// tlprf_back
// Executes commands against the two byte queues and drives the result
// register, one result per cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
module tlprf_back #(
    parameter int DEPTH        = 128,
    parameter int RECORD_BYTES = 11
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tlprf_pkg::cmd_t    cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic               m_source_queue,
    output logic [7:0]         m_out_byte,
    output logic               m_last_of_run
);
    import tlprf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } state_t;

    logic [7:0]    mem_reg [2][DEPTH];

    state_t        state_reg, state_next;
    logic [AW-1:0] rd_ptr_reg [2], rd_ptr_next [2];
    logic [AW-1:0] wr_ptr_reg [2], wr_ptr_next [2];
    logic [CW-1:0] count_reg  [2], count_next  [2];
    logic [PW-1:0] phase_reg  [2], phase_next  [2];
    logic          open_reg   [2], open_next   [2];
    logic [PW-1:0] remain_reg, remain_next;
    logic          src_reg, src_next;

    logic          valid_reg, valid_next;
    status_e_t     status_reg, status_next;
    logic          srcq_reg, srcq_next;
    logic [7:0]    byte_reg;
    logic          last_reg, last_next;

    logic          slot_free;
    logic          push_we;
    logic          push_q;
    logic          pop_re;
    logic          pop_q;

    assign slot_free = !valid_reg || m_ready;
    assign cmd_ready = (state_reg == S_IDLE) && slot_free;
    assign push_q    = cmd.queue;

    always_comb begin
        logic q;
        logic open;
        logic take;
        logic src;
        logic nonempty;

        state_next  = state_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        open_next   = open_reg;
        remain_next = remain_reg;
        src_next    = src_reg;
        valid_next  = slot_free ? 1'b0 : valid_reg;
        status_next = status_reg;
        srcq_next   = srcq_reg;
        last_next   = last_reg;
        push_we     = 1'b0;
        pop_re      = 1'b0;
        pop_q       = src_reg;
        q           = cmd.queue;
        open        = 1'b0;
        take        = 1'b0;
        src         = QUEUE_HIGH;
        nonempty    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && slot_free) begin
                    case (cmd.kind) inside
                        CMD_PUSH_START, CMD_PUSH_CONT: begin
                            // decide once per record, on its first byte
                            if (cmd.kind == CMD_PUSH_START) begin
                                open = (count_reg[q] <= CW'(DEPTH - RECORD_BYTES));
                            end else begin
                                open = open_reg[q];
                            end
                            open_next[q] = open;
                            take = open && (count_reg[q] != CW'(DEPTH));
                            if (take) begin
                                push_we        = 1'b1;
                                wr_ptr_next[q] = (wr_ptr_reg[q] == AW'(DEPTH - 1)) ?
                                                 '0 : wr_ptr_reg[q] + 1'b1;
                                count_next[q]  = count_reg[q] + 1'b1;
                                phase_next[q]  = (phase_reg[q] == PW'(RECORD_BYTES - 1)) ?
                                                 '0 : phase_reg[q] + 1'b1;
                            end
                            valid_next  = 1'b1;
                            status_next = take ? STAT_ACCEPTED : STAT_DROPPED;
                            srcq_next   = q;
                            last_next   = 1'b1;
                        end
                        CMD_POP: begin
                            nonempty = 1'b1;
                            if (count_reg[QUEUE_HIGH] != '0) begin
                                src = QUEUE_HIGH;
                            end else if (count_reg[QUEUE_LOW] != '0) begin
                                src = QUEUE_LOW;
                            end else begin
                                nonempty = 1'b0;
                            end
                            valid_next = 1'b1;
                            srcq_next  = src;
                            last_next  = 1'b1;
                            if (!nonempty) begin
                                status_next = STAT_EMPTY;
                            end else if (phase_reg[src] != '0) begin
                                status_next = STAT_MISALIGNED;
                            end else begin
                                pop_re      = 1'b1;
                                pop_q       = src;
                                src_next    = src;
                                status_next = STAT_POPPED;
                                last_next   = (RECORD_BYTES == 1);
                                remain_next = PW'(RECORD_BYTES - 1);
                                if (RECORD_BYTES > 1) begin
                                    state_next = S_POP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                if (slot_free) begin
                    pop_re      = 1'b1;
                    valid_next  = 1'b1;
                    status_next = STAT_POPPED;
                    srcq_next   = src_reg;
                    last_next   = (remain_reg == PW'(1));
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == PW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (pop_re) begin
            rd_ptr_next[pop_q] = (rd_ptr_reg[pop_q] == AW'(DEPTH - 1)) ?
                                 '0 : rd_ptr_reg[pop_q] + 1'b1;
            count_next[pop_q]  = count_reg[pop_q] - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            rd_ptr_reg <= '{default: '0};
            wr_ptr_reg <= '{default: '0};
            count_reg  <= '{default: '0};
            phase_reg  <= '{default: '0};
            open_reg   <= '{default: 1'b0};
            remain_reg <= '0;
            src_reg    <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            open_reg   <= open_next;
            remain_reg <= remain_next;
            src_reg    <= src_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        srcq_reg   <= srcq_next;
        last_reg   <= last_next;
        if (slot_free) begin
            // read data lands directly in the result register
            byte_reg <= pop_re ? mem_reg[pop_q][rd_ptr_reg[pop_q]] : 8'd0;
        end
        if (push_we) begin
            mem_reg[push_q][wr_ptr_reg[push_q]] <= cmd.data;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = status_reg;
    assign m_source_queue = srcq_reg;
    assign m_out_byte     = byte_reg;
    assign m_last_of_run  = last_reg;

endmodule

// ----- src/two_level_priority_record_fifo_top.sv -----
// ----------------------------------------------------------------------------
// two_level_priority_record_fifo_top
// Strict-priority pair of byte queues holding fixed-length records.
// ----------------------------------------------------------------------------
// Input channel (s_): one beat is a push of one byte to the high or low
// queue, or a pop of one record. Result channel (m_): a push gives one
// result (accepted or dropped); a pop gives RECORD_BYTES byte results from
// the high queue if it holds any byte, else from the low queue, or a single
// status result when both are empty or the chosen queue is misaligned.
// m_last_of_run marks the final result of each input beat.
// With the back end idle, an accepted beat is first written into the command
// queue, and its first result is then loaded into the result register.
// A pop streams its bytes from the byte storage, one byte per cycle while
// the receiver keeps up; the back end takes no new command until the pop
// is through.
// A two-entry command queue sits between intake and execution, so inputs
// are still taken while a pop streams or a result waits.
// Reset clears pointers, counts and record state; storage is not cleared
// and no clearing pass is needed. When the receiver stalls, the result
// register holds and execution pauses; intake stops once the command queue
// is full.
// ----------------------------------------------------------------------------
module two_level_priority_record_fifo_top #(
    parameter int DEPTH        = 128,
    parameter int RECORD_BYTES = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic        s_queue_select,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_of_record,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_source_queue,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run
);
    import tlprf_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    tlprf_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_queue_select    (s_queue_select),
        .s_data_byte       (s_data_byte),
        .s_first_of_record (s_first_of_record),
        .cmd_valid         (cmd_valid),
        .cmd_ready         (cmd_ready),
        .cmd               (cmd)
    );

    tlprf_back #(
        .DEPTH        (DEPTH),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_source_queue (m_source_queue),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run)
    );

`ifndef SYNTH
    // non-byte results carry a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_POPPED) |-> (m_out_byte == 8'd0))
        else $error("non-byte result carries a nonzero byte");

    // only a record pop produces more than one result per beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> (m_status == STAT_POPPED))
        else $error("multi-result run with non-byte status");

    // both-empty status always reports the high queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_EMPTY) |-> (m_source_queue == QUEUE_HIGH))
        else $error("empty status with low queue tag");

    // a full command queue always offers a command to the back end
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> cmd_valid)
        else $error("intake stalled with no pending command");
`endif

endmodule

// ----- sim/tlprf_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlprf_tb_pkg
// Operation codes of the input beat, shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package tlprf_tb_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

endpackage

// ----- sim/tlprf_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlprf_scoreboard
// Watches both channels of the priority record FIFO, runs its own model of
// the two byte queues on every input beat and compares each result beat,
// field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
module tlprf_scoreboard
    import tlprf_pkg::*;
    import tlprf_tb_pkg::*;
#(
    parameter int DEPTH        = 128,
    parameter int RECORD_BYTES = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_operation,
    input  logic             s_queue_select,
    input  logic [7:0]       s_data_byte,
    input  logic             s_first_of_record,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [2:0]       m_status,
    input  logic             m_source_queue,
    input  logic [7:0]       m_out_byte,
    input  logic             m_last_of_run,
    output int               mismatch_count,
    output int               results_pending,
    output int               results_checked,
    output int               drops_seen,
    output int               empties_seen,
    output int               misaligned_seen,
    output logic [1:0][15:0] fill_level,
    output logic [1:0]       record_open
);

    typedef struct packed {
        status_e_t  status;
        logic       src;
        logic [7:0] data;
        logic       last;
    } fifo_result_t;

    fifo_result_t expected_results[$];
    logic [7:0]   byte_store [2][DEPTH];
    int unsigned  rd_ptr   [2];
    int unsigned  wr_ptr   [2];
    int unsigned  fill_cnt [2];
    bit           open_flag[2];
    int           errors;
    int           checked_total;
    int           drop_total;
    int           empty_total;
    int           misaligned_total;

    initial begin
        errors           = 0;
        checked_total    = 0;
        drop_total       = 0;
        empty_total      = 0;
        misaligned_total = 0;
        mismatch_count   = 0;
        results_pending  = 0;
        results_checked  = 0;
        drops_seen       = 0;
        empties_seen     = 0;
        misaligned_seen  = 0;
        fill_level       = '0;
        record_open      = '0;
    end

    task automatic queue_result(input status_e_t st, input logic src, input logic [7:0] data,
                                input logic last);
        fifo_result_t r;
        r.status = st;
        r.src    = src;
        r.data   = data;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_fifo_response(input logic op, input logic q, input logic [7:0] data,
                                         input logic first);
        bit   take;
        logic src;
        int   k;
        if (op == OP_PUSH) begin
            // the first byte decides for the whole record
            if (first) begin
                open_flag[q] = (fill_cnt[q] <= DEPTH - RECORD_BYTES);
            end
            take = open_flag[q] && (fill_cnt[q] < DEPTH);
            if (take) begin
                byte_store[q][wr_ptr[q]] = data;
                wr_ptr[q] = (wr_ptr[q] + 1) % DEPTH;
                fill_cnt[q]++;
                queue_result(STAT_ACCEPTED, q, 8'h00, 1'b1);
            end else begin
                queue_result(STAT_DROPPED, q, 8'h00, 1'b1);
            end
        end else if (fill_cnt[QUEUE_HIGH] == 0 && fill_cnt[QUEUE_LOW] == 0) begin
            queue_result(STAT_EMPTY, QUEUE_HIGH, 8'h00, 1'b1);
        end else begin
            src = (fill_cnt[QUEUE_HIGH] != 0) ? QUEUE_HIGH : QUEUE_LOW;
            if (fill_cnt[src] % RECORD_BYTES != 0) begin
                queue_result(STAT_MISALIGNED, src, 8'h00, 1'b1);
            end else begin
                for (k = 0; k < RECORD_BYTES; k++) begin
                    queue_result(STAT_POPPED, src, byte_store[src][rd_ptr[src]],
                                 k == RECORD_BYTES - 1);
                    rd_ptr[src] = (rd_ptr[src] + 1) % DEPTH;
                    fill_cnt[src]--;
                end
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_result_beat();
        fifo_result_t want;
        if (expected_results.size() == 0) begin
            note_mismatch($sformatf("beat with nothing pending: status %0d queue %0d byte 0x%02h last %0d",
                                    m_status, m_source_queue, m_out_byte, m_last_of_run));
        end else begin
            want = expected_results.pop_front();
            checked_total++;
            case (want.status)
                STAT_DROPPED:    drop_total++;
                STAT_EMPTY:      empty_total++;
                STAT_MISALIGNED: misaligned_total++;
                default: ;
            endcase
            if (m_status !== want.status || m_source_queue !== want.src ||
                m_out_byte !== want.data || m_last_of_run !== want.last) begin
                note_mismatch($sformatf({"result %0d: expected status %0d queue %0d byte 0x%02h ",
                                         "last %0d, got status %0d queue %0d byte 0x%02h last %0d"},
                                        checked_total, want.status, want.src, want.data,
                                        want.last, m_status, m_source_queue, m_out_byte,
                                        m_last_of_run));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr    = '{0, 0};
            wr_ptr    = '{0, 0};
            fill_cnt  = '{0, 0};
            open_flag = '{1'b0, 1'b0};
            expected_results.delete();
        end else begin
            // a result never stems from the input beat taken at the same edge
            if (m_valid && m_ready) begin
                check_result_beat();
            end
            if (s_valid && s_ready) begin
                predict_fifo_response(s_operation, s_queue_select, s_data_byte,
                                      s_first_of_record);
            end
        end
        mismatch_count  <= errors;
        results_pending <= expected_results.size();
        results_checked <= checked_total;
        drops_seen      <= drop_total;
        empties_seen    <= empty_total;
        misaligned_seen <= misaligned_total;
        fill_level      <= {fill_cnt[1][15:0], fill_cnt[0][15:0]};
        record_open     <= {open_flag[1], open_flag[0]};
    end

endmodule

// ----- sim/tb_two_level_priority_record_fifo_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_level_priority_record_fifo_top
// Drives push and pop beats into the priority record FIFO: a directed
// opening, a random mix of whole records, broken records and noise, then a
// full-queue overrun. Both sides idle in bursts; the checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_two_level_priority_record_fifo_top;
    import tlprf_pkg::*;
    import tlprf_tb_pkg::*;

    localparam int DEPTH        = 128;
    localparam int RECORD_BYTES = 11;
    localparam int RANDOM_BEATS = 240;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_operation;
    logic             s_queue_select;
    logic [7:0]       s_data_byte;
    logic             s_first_of_record;
    logic             m_valid;
    logic             m_ready;
    logic [2:0]       m_status;
    logic             m_source_queue;
    logic [7:0]       m_out_byte;
    logic             m_last_of_run;

    int               mismatch_count;
    int               results_pending;
    int               results_checked;
    int               drops_seen;
    int               empties_seen;
    int               misaligned_seen;
    logic [1:0][15:0] fill_level;
    logic [1:0]       record_open;

    int               beats_sent;
    int               push_beats;
    int               pop_beats;
    int               stall_cycles;
    bit               tail_phase;
    bit               tx_bursty;
    bit               rx_bursty;
    bit               hold_request;
    bit               hold_done;

    two_level_priority_record_fifo_top #(
        .DEPTH        (DEPTH),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_queue_select    (s_queue_select),
        .s_data_byte       (s_data_byte),
        .s_first_of_record (s_first_of_record),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_source_queue    (m_source_queue),
        .m_out_byte        (m_out_byte),
        .m_last_of_run     (m_last_of_run)
    );

    tlprf_scoreboard #(
        .DEPTH        (DEPTH),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_scoreboard (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_queue_select    (s_queue_select),
        .s_data_byte       (s_data_byte),
        .s_first_of_record (s_first_of_record),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_source_queue    (m_source_queue),
        .m_out_byte        (m_out_byte),
        .m_last_of_run     (m_last_of_run),
        .mismatch_count    (mismatch_count),
        .results_pending   (results_pending),
        .results_checked   (results_checked),
        .drops_seen        (drops_seen),
        .empties_seen      (empties_seen),
        .misaligned_seen   (misaligned_seen),
        .fill_level        (fill_level),
        .record_open       (record_open)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned fill_of(input logic q);
        return {16'd0, fill_level[q]};
    endfunction

    function automatic bit misaligned(input logic q);
        return (fill_of(q) % RECORD_BYTES) != 0;
    endfunction

    // Offer one beat at the falling edge and hold it until taken.
    task automatic send_beat(input logic op, input logic q, input logic [7:0] data,
                             input logic first);
        if (!tail_phase && tx_bursty && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_operation       <= op;
        s_queue_select    <= q;
        s_data_byte       <= data;
        s_first_of_record <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
        if (op == OP_PUSH) begin
            push_beats++;
        end else begin
            pop_beats++;
        end
    endtask

    task automatic push_record(input logic q, input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_beat(OP_PUSH, q, 8'($urandom_range(0, 255)), i == 0);
        end
    endtask

    task automatic pop_record();
        send_beat(OP_POP, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    // Top the queue up to a whole number of records: extend the open record,
    // or start a short one.
    task automatic realign(input logic q);
        int unsigned missing;
        bit          start_new;
        int          i;
        missing   = RECORD_BYTES - fill_of(q) % RECORD_BYTES;
        start_new = !record_open[q];
        for (i = 0; i < missing; i++) begin
            send_beat(OP_PUSH, q, 8'($urandom_range(0, 255)), start_new && i == 0);
        end
    endtask

    // Receiver: idle bursts, one long hold-off, steady at the end.
    initial begin
        m_ready   = 1'b0;
        rx_bursty = 1'b1;
        hold_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 59) == 0) begin
                rx_bursty = !rx_bursty;
            end
            if (!tail_phase && hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!tail_phase && rx_bursty && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Nothing accepted on either side for too long ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int   roll;
        int   len;
        int   fill_bias;
        int   i;
        logic q;
        logic op;

        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_operation       = OP_PUSH;
        s_queue_select    = QUEUE_HIGH;
        s_data_byte       = 8'h00;
        s_first_of_record = 1'b0;
        beats_sent        = 0;
        push_beats        = 0;
        pop_beats         = 0;
        stall_cycles      = 0;
        tail_phase        = 1'b0;
        tx_bursty         = 1'b1;
        hold_request      = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening: continuation with no open record, pop of empty
        // queues, a full record carrying the byte extremes, a short record
        // that leaves the high queue misaligned, a pop that meets it, then its completion.
        send_beat(OP_PUSH, QUEUE_HIGH, 8'h5A, 1'b0);
        send_beat(OP_POP, QUEUE_LOW, 8'hFF, 1'b1);
        for (i = 0; i < RECORD_BYTES; i++) begin
            send_beat(OP_PUSH, QUEUE_LOW,
                      (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                      i == 0);
        end
        push_record(QUEUE_HIGH, 3);
        pop_record();
        realign(QUEUE_HIGH);

        // Random part: mostly whole records and pops, with broken records
        // and noise; misaligned queues get a pop or a repair before anything else.
        while (beats_sent < 25 + RANDOM_BEATS) begin
            if (beats_sent >= 100) begin
                hold_request = 1'b1;
            end
            if ($urandom_range(0, 29) == 0) begin
                tx_bursty = !tx_bursty;
            end
            fill_bias = ((beats_sent / 70) % 2 == 0) ? 55 : 25;
            roll      = $urandom_range(0, 99);
            q         = 1'($urandom_range(0, 1));
            if (misaligned(QUEUE_HIGH) || misaligned(QUEUE_LOW)) begin
                if ($urandom_range(0, 1) == 0) begin
                    pop_record();
                end else begin
                    realign(misaligned(QUEUE_HIGH) ? QUEUE_HIGH : QUEUE_LOW);
                end
            end else if (roll < fill_bias) begin
                push_record(q, RECORD_BYTES);
            end else if (roll < 85) begin
                pop_record();
            end else if (roll < 93) begin
                len = $urandom_range(1, 2 * RECORD_BYTES - 1);
                if (len == RECORD_BYTES) begin
                    len = 1;
                end
                if (fill_of(q) <= 90) begin
                    push_record(q, len);
                end else begin
                    pop_record();
                end
            end else begin
                op = 1'($urandom_range(0, 1));
                if (op == OP_PUSH && fill_of(q) > 100) begin
                    op = OP_POP;
                end
                send_beat(op, q, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end

        // Tail: no idling. Fill the low queue, run past its end inside an
        // accepted record, offer a record that must be refused, then drain the high queue.
        tail_phase = 1'b1;
        if (misaligned(QUEUE_HIGH)) begin
            realign(QUEUE_HIGH);
        end
        if (misaligned(QUEUE_LOW)) begin
            realign(QUEUE_LOW);
        end
        while (fill_of(QUEUE_LOW) <= DEPTH - RECORD_BYTES) begin
            push_record(QUEUE_LOW, RECORD_BYTES);
        end
        repeat (15) send_beat(OP_PUSH, QUEUE_LOW, 8'($urandom_range(0, 255)), 1'b0);
        push_record(QUEUE_LOW, RECORD_BYTES);
        while (fill_of(QUEUE_HIGH) != 0) begin
            pop_record();
        end
        repeat (2) pop_record();
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);

        $display("Run covered %0d input beats (%0d pushes, %0d pops) and %0d checked results.",
                 beats_sent, push_beats, pop_beats, results_checked);
        $display("Among them %0d dropped pushes, %0d empty pops, %0d misaligned pops.",
                 drops_seen, empties_seen, misaligned_seen);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
